// ===== hdl/signed_integer_text_parser_assert.svh =====
// ---------------------------------------------------------------------------
// signed_integer_text_parser assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TEXT_PARSER_ASSERT_SVH
`define SIGNED_INTEGER_TEXT_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sitp_pkg.sv =====
// ---------------------------------------------------------------------------
// sitp_pkg
// shared types and constants of the signed integer text parser
// ---------------------------------------------------------------------------
package sitp_pkg;

  // defaults for top level parameters
  localparam int unsigned     QUEUE_DEPTH = 4;
  localparam longint unsigned MAX_LEN     = 65535;

  // character codes
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SOFT_MINUS = 8'hAD;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UP_A       = 8'h41;
  localparam logic [7:0] CH_UP_Z       = 8'h5A;
  localparam logic [7:0] CH_LO_A       = 8'h61;
  localparam logic [7:0] CH_LO_Z       = 8'h7A;
  localparam logic [7:0] CH_UP_X       = 8'h58;
  localparam logic [7:0] CH_LO_X       = 8'h78;

  // number bases
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] BASE_AUTO   = 6'd0;
  localparam logic [5:0] BASE_OCT    = 6'd8;
  localparam logic [5:0] BASE_DEC    = 6'd10;
  localparam logic [5:0] BASE_HEX    = 6'd16;

  // saturation limits
  localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

  // input item
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        end_offset;
    logic               overflow;
    logic               had_digits;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic       first;
    logic       no_digit;
    logic [5:0] digit;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
  } cls_item_t;

endpackage

// ===== hdl/sitp_front.sv =====
// ---------------------------------------------------------------------------
// sitp_front
// accepts input items and classifies each character for the back end
// ---------------------------------------------------------------------------
module sitp_front (
  input  logic                 in_valid,
  input  sitp_pkg::in_item_t   in_item,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 q_push,
  output sitp_pkg::cls_item_t  q_item
);

  logic [7:0] ch;
  logic       is_num;
  logic       is_up;
  logic       is_lo;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign ch       = in_item.ch;

  // digit value of 0-9, A-Z, a-z
  assign is_num = (ch >= sitp_pkg::CH_ZERO) && (ch <= sitp_pkg::CH_NINE);
  assign is_up  = (ch >= sitp_pkg::CH_UP_A) && (ch <= sitp_pkg::CH_UP_Z);
  assign is_lo  = (ch >= sitp_pkg::CH_LO_A) && (ch <= sitp_pkg::CH_LO_Z);

  always_comb begin
    q_item          = '0;
    q_item.first    = in_item.first;
    q_item.no_digit = !(is_num || is_up || is_lo);
    priority if (is_num) begin
      q_item.digit = 6'(ch - sitp_pkg::CH_ZERO);
    end else if (is_up) begin
      q_item.digit = 6'(ch - (sitp_pkg::CH_UP_A - 8'd10));
    end else if (is_lo) begin
      q_item.digit = 6'(ch - (sitp_pkg::CH_LO_A - 8'd10));
    end else begin
      q_item.digit = '0;
    end
    q_item.is_space = (ch == sitp_pkg::CH_SPACE);
    q_item.is_minus = (ch == sitp_pkg::CH_MINUS) || (ch == sitp_pkg::CH_SOFT_MINUS);
    q_item.is_plus  = (ch == sitp_pkg::CH_PLUS);
    q_item.is_zero  = (ch == sitp_pkg::CH_ZERO);
    q_item.is_x     = (ch == sitp_pkg::CH_UP_X) || (ch == sitp_pkg::CH_LO_X);
  end

endmodule

// ===== hdl/sitp_fifo.sv =====
// ---------------------------------------------------------------------------
// sitp_fifo
// short queue of classified items between front and back
// ---------------------------------------------------------------------------
module sitp_fifo #(
  parameter int unsigned DEPTH = sitp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  sitp_pkg::cls_item_t         push_item,
  input  logic                        pop,
  output sitp_pkg::cls_item_t         head_item,
  output logic                        full,
  output logic                        not_empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sitp_pkg::cls_item_t mem_r [DEPTH];
  logic [IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign head_item = mem_r[rd_ptr_r];
  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/sitp_back.sv =====
// ---------------------------------------------------------------------------
// sitp_back
// parse sequencer: sign, prefix and digit accumulation, result register
// ---------------------------------------------------------------------------
module sitp_back #(
  parameter longint unsigned MAX_LEN = sitp_pkg::MAX_LEN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_wdata,
  input  logic                 q_valid,
  input  sitp_pkg::cls_item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output sitp_pkg::out_item_t  out_item,
  input  logic                 out_stall
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int EXT_W = (POS_W > 16) ? POS_W : 16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_t;

  phase_t              phase_r, phase_nxt, ph_e;
  logic [31:0]         acc_r, acc_nxt, acc_e;
  logic                neg_r, neg_nxt, neg_e;
  logic                sat_r, sat_nxt, sat_e;
  logic                seen_r, seen_nxt, seen_e;
  logic [5:0]          base_r, base_nxt, base_e;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos_e;
  logic [5:0]          radix_r;
  logic                out_valid_r, out_valid_nxt;
  sitp_pkg::out_item_t out_item_r, out_item_nxt;

  logic                lead;
  logic                use_db;
  logic [5:0]          db_base;
  logic                db_seen;
  logic                term;
  logic [37:0]         next_val;
  logic [37:0]         limit;
  logic                over;
  logic [EXT_W-1:0]    pos_x;
  logic [EXT_W-1:0]    pos_m1;
  logic                emit;
  sitp_pkg::out_item_t emit_item;

  // take the next item when the result slot is free or draining
  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    // state as seen by this item, after a start byte resets it
    if (q_item.first) begin
      ph_e   = PH_SPACE;
      acc_e  = '0;
      neg_e  = 1'b0;
      sat_e  = 1'b0;
      seen_e = 1'b0;
      base_e = radix_r;
      pos_e  = '0;
    end else begin
      ph_e   = phase_r;
      acc_e  = acc_r;
      neg_e  = neg_r;
      sat_e  = sat_r;
      seen_e = seen_r;
      base_e = base_r;
      pos_e  = pos_r;
    end

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    seen_nxt  = seen_r;
    base_nxt  = base_r;
    pos_nxt   = pos_r;
    lead      = 1'b0;
    use_db    = 1'b0;
    db_base   = base_e;
    db_seen   = seen_e;
    emit      = 1'b0;
    emit_item = '0;
    pos_x     = EXT_W'(pos_e);
    pos_m1    = pos_x - EXT_W'(1);

    if (q_pop) begin
      phase_nxt = ph_e;
      acc_nxt   = acc_e;
      neg_nxt   = neg_e;
      sat_nxt   = sat_e;
      seen_nxt  = seen_e;
      base_nxt  = base_e;
      pos_nxt   = pos_e;

      // phase decode
      unique case (ph_e)
        PH_IDLE: begin
        end
        PH_SPACE: begin
          priority if (q_item.is_space) begin
          end else if (q_item.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGNED;
          end else if (q_item.is_plus) begin
            phase_nxt = PH_SIGNED;
          end else begin
            lead = 1'b1;
          end
        end
        PH_SIGNED: begin
          lead = 1'b1;
        end
        PH_ZERO: begin
          if (q_item.is_x) begin
            base_nxt  = sitp_pkg::BASE_HEX;
            phase_nxt = PH_HEXPFX;
          end else begin
            // the leading zero counts as a digit of value zero
            db_base  = (base_e == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_OCT
                                                       : sitp_pkg::BASE_HEX;
            base_nxt = db_base;
            db_seen  = 1'b1;
            seen_nxt = 1'b1;
            use_db   = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (!q_item.no_digit && (q_item.digit < sitp_pkg::BASE_HEX)) begin
            db_base = sitp_pkg::BASE_HEX;
            use_db  = 1'b1;
          end else begin
            // prefix with no hex digit: subject is the lone zero
            emit                 = 1'b1;
            emit_item.value      = '0;
            emit_item.end_offset = pos_m1[15:0];
            emit_item.overflow   = 1'b0;
            emit_item.had_digits = 1'b1;
            phase_nxt            = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          use_db = 1'b1;
        end
        default: begin
        end
      endcase

      // first byte after spaces and sign
      if (lead) begin
        if (q_item.is_zero && ((base_e == sitp_pkg::BASE_AUTO) ||
                               (base_e == sitp_pkg::BASE_HEX))) begin
          phase_nxt = PH_ZERO;
        end else begin
          db_base  = (base_e == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_DEC : base_e;
          base_nxt = db_base;
          use_db   = 1'b1;
        end
      end

      // position advances on every byte of a live string, up to MAX_LEN
      if (ph_e != PH_IDLE) begin
        pos_nxt = (pos_e < POS_W'(MAX_LEN)) ? pos_e + POS_W'(1) : pos_e;
      end
    end

    // digit step: multiply-add and saturation compare
    term     = q_item.no_digit || (q_item.digit >= db_base);
    next_val = 38'(acc_e) * 38'(db_base) + 38'(q_item.digit);
    limit    = neg_e ? 38'(sitp_pkg::LIMIT_NEG) : 38'(sitp_pkg::LIMIT_POS);
    over     = next_val > limit;

    if (q_pop && use_db) begin
      if (term) begin
        emit = 1'b1;
        if (sat_e) begin
          emit_item.value = neg_e ? sitp_pkg::LIMIT_NEG : sitp_pkg::LIMIT_POS;
        end else begin
          emit_item.value = neg_e ? 32'(32'd0 - acc_e) : acc_e;
        end
        emit_item.end_offset = db_seen ? pos_x[15:0] : 16'd0;
        emit_item.overflow   = sat_e;
        emit_item.had_digits = db_seen;
        phase_nxt            = PH_IDLE;
      end else begin
        seen_nxt  = 1'b1;
        sat_nxt   = sat_e || over;
        acc_nxt   = (sat_e || over) ? acc_e : next_val[31:0];
        phase_nxt = PH_DIGITS;
      end
    end

    // result register
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end
  end

  // parse state, radix register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      sat_r       <= 1'b0;
      seen_r      <= 1'b0;
      base_r      <= sitp_pkg::BASE_DEC;
      pos_r       <= '0;
      radix_r     <= sitp_pkg::RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      sat_r       <= sat_nxt;
      seen_r      <= seen_nxt;
      base_r      <= base_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
    end
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hdl/signed_integer_text_parser.sv =====
// ---------------------------------------------------------------------------
// signed_integer_text_parser
// streaming strtol-style parser of signed 32-bit integers from text
// ---------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_item carry one character per item; in_item.first
//   marks the first character of a new string and latches the radix.
//   out_valid/out_stall/out_item carry one result per parsed string: value,
//   end offset, overflow and digits-seen flags, on the first non-digit.
//   cfg_we/cfg_wdata write the radix (0 = automatic, reset value 10); write
//   it only while no string is in flight.
// throughput and result path:
//   one character per cycle sustained while no stalled result holds the back
//   end; the digit multiply-add and limit compare in the back end complete in
//   the cycle the item leaves the queue, which loads the result register; a
//   terminating item reaches the result register only through the queue.
// reset:
//   rst_n low empties the queue, drops any pending result and returns the
//   parser to idle; characters before the next start item are ignored.
// stall:
//   a stalled result holds; the back end stops draining the queue, and
//   in_stall rises once QUEUE_DEPTH items are waiting.
// ---------------------------------------------------------------------------
module signed_integer_text_parser #(
  parameter int unsigned     QUEUE_DEPTH = sitp_pkg::QUEUE_DEPTH,
  parameter longint unsigned MAX_LEN     = sitp_pkg::MAX_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  input  logic                in_valid,
  input  sitp_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output sitp_pkg::out_item_t out_item,
  input  logic                out_stall
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sitp_pkg::cls_item_t push_item;
  sitp_pkg::cls_item_t head_item;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_valid;
  logic [CNT_W-1:0]    q_count;
  logic [CNT_W-1:0]    q_count_inc;

  // character classification
  sitp_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // decoupling queue
  sitp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .not_empty (q_valid),
    .count     (q_count)
  );

  // parse sequencer
  sitp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // fill count one above the current one
  assign q_count_inc = q_count + CNT_W'(1);

  // checks
`include "signed_integer_text_parser_assert.svh"

  `SITP_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `SITP_ASSERT_NOW(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")
  `SITP_ASSERT_NEXT(a_push_count, q_push && !q_pop, q_count == $past(q_count_inc), "missed push")
  `SITP_ASSERT_NOW(a_result_from_pop, $rose(out_valid), $past(q_pop), "result without pop")

endmodule

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming signed integer text parser: a
// behavioral parser predicts every result from the accepted characters, a
// monitor compares each result item field by field in arrival order, and
// directed strings, a long string and random strings run under three
// sender/receiver idling profiles and several radix settings
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int         STUCK_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = sitp_pkg::QUEUE_DEPTH + 12;
  localparam int         BLOCK_CHARS  = 100;
  localparam int         REPORT_MAX   = 10;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] NO_DIGIT     = 8'hFF;
  localparam int         RADIX_RANDOM = -1;

  typedef enum logic [2:0] {
    PS_IDLE, PS_SPACE, PS_SIGN, PS_ZERO, PS_PREFIX, PS_DIGITS
  } parse_state_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [5:0]          cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  sitp_pkg::in_item_t  in_item   = '0;
  logic                in_stall;
  logic                out_valid;
  sitp_pkg::out_item_t out_item;
  logic                out_stall = 1'b0;

  // idling percentages of each side
  int tx_idle = 0;
  int rx_idle = 0;

  // run statistics
  int errors        = 0;
  int chars_sent    = 0;
  int results_seen  = 0;
  int saturated_cnt = 0;
  int no_digit_cnt  = 0;
  int radix_writes  = 0;
  int stuck_cycles  = 0;

  // radix settings walked by the random phases
  int radix_plan[12] = '{0, 10, 2, 36, 16, 1, 63, 8,
                         RADIX_RANDOM, RADIX_RANDOM, 0, 16};

  // parser state mirror
  parse_state_t ps        = PS_IDLE;
  logic [31:0]  acc       = '0;
  logic         neg       = 1'b0;
  logic         sat       = 1'b0;
  logic         seen      = 1'b0;
  logic [5:0]   base      = sitp_pkg::BASE_DEC;
  logic [15:0]  pos       = '0;
  logic [5:0]   radix_cur = sitp_pkg::RADIX_RESET;

  sitp_pkg::out_item_t parsed_q[$];

  signed_integer_text_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // parser prediction
  // ------------------------------------------------------------------
  function automatic logic [7:0] digit_val(input logic [7:0] b);
    if (b >= sitp_pkg::CH_ZERO && b <= sitp_pkg::CH_NINE) return b - sitp_pkg::CH_ZERO;
    if (b >= sitp_pkg::CH_UP_A && b <= sitp_pkg::CH_UP_Z)
      return b - sitp_pkg::CH_UP_A + 8'd10;
    if (b >= sitp_pkg::CH_LO_A && b <= sitp_pkg::CH_LO_Z)
      return b - sitp_pkg::CH_LO_A + 8'd10;
    return NO_DIGIT;
  endfunction

  task automatic push_result(input logic [31:0] v, input logic [15:0] e,
                             input logic ovf, input logic dig);
    sitp_pkg::out_item_t r;
    r.value      = v;
    r.end_offset = e;
    r.overflow   = ovf;
    r.had_digits = dig;
    parsed_q.push_back(r);
    ps = PS_IDLE;
  endtask

  // multiply-add with saturation at the signed limit
  task automatic accumulate(input logic [7:0] d);
    logic [63:0] lim;
    logic [63:0] nxt;
    lim  = neg ? {32'd0, sitp_pkg::LIMIT_NEG} : {32'd0, sitp_pkg::LIMIT_POS};
    nxt  = {32'd0, acc} * {58'd0, base} + {56'd0, d};
    seen = 1'b1;
    if (sat || nxt > lim) sat = 1'b1;
    else acc = nxt[31:0];
  endtask

  task automatic digit_step(input logic [7:0] b);
    logic [7:0]  d;
    logic [31:0] v;
    d = digit_val(b);
    if (d >= {2'b00, base}) begin
      if (sat) v = neg ? sitp_pkg::LIMIT_NEG : sitp_pkg::LIMIT_POS;
      else v = neg ? (32'd0 - acc) : acc;
      push_result(v, seen ? pos : 16'd0, sat, seen);
    end else begin
      accumulate(d);
      ps = PS_DIGITS;
    end
  endtask

  // first byte after spaces and sign: a zero may open a hex prefix
  task automatic lead_step(input logic [7:0] b);
    if (b == sitp_pkg::CH_ZERO &&
        (base == sitp_pkg::BASE_AUTO || base == sitp_pkg::BASE_HEX)) begin
      ps = PS_ZERO;
    end else begin
      if (base == sitp_pkg::BASE_AUTO) base = sitp_pkg::BASE_DEC;
      digit_step(b);
    end
  endtask

  task automatic predict_char(input sitp_pkg::in_item_t it);
    logic [7:0] b;
    b = it.ch;
    if (it.first) begin
      ps   = PS_SPACE;
      acc  = '0;
      neg  = 1'b0;
      sat  = 1'b0;
      seen = 1'b0;
      base = radix_cur;
      pos  = '0;
    end
    case (ps)
      PS_IDLE: return;
      PS_SPACE: begin
        if (b == sitp_pkg::CH_SPACE) begin
        end else if (b == sitp_pkg::CH_MINUS || b == sitp_pkg::CH_SOFT_MINUS) begin
          neg = 1'b1;
          ps  = PS_SIGN;
        end else if (b == sitp_pkg::CH_PLUS) begin
          ps = PS_SIGN;
        end else begin
          lead_step(b);
        end
      end
      PS_SIGN: lead_step(b);
      PS_ZERO: begin
        if (b == sitp_pkg::CH_LO_X || b == sitp_pkg::CH_UP_X) begin
          base = sitp_pkg::BASE_HEX;
          ps   = PS_PREFIX;
        end else begin
          base = (base == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_OCT : sitp_pkg::BASE_HEX;
          accumulate(8'd0);
          digit_step(b);
        end
      end
      // prefix without a hex digit falls back to the lone zero
      PS_PREFIX: begin
        if (digit_val(b) < {2'b00, sitp_pkg::BASE_HEX}) digit_step(b);
        else push_result('0, pos - 16'd1, 1'b0, 1'b1);
      end
      PS_DIGITS: digit_step(b);
      default: return;
    endcase
    if (pos < sitp_pkg::MAX_LEN) pos = pos + 16'd1;
  endtask

  // ------------------------------------------------------------------
  // result monitor and receiver stall
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    sitp_pkg::out_item_t want;
    out_stall <= ($urandom_range(99) < rx_idle);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (parsed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("tb_top: unexpected result value=%0d end=%0d ovf=%0b dig=%0b",
                   out_item.value, out_item.end_offset, out_item.overflow,
                   out_item.had_digits);
      end else begin
        want = parsed_q.pop_front();
        if (want.overflow) saturated_cnt++;
        if (!want.had_digits) no_digit_cnt++;
        if (out_item.value !== want.value || out_item.end_offset !== want.end_offset ||
            out_item.overflow !== want.overflow ||
            out_item.had_digits !== want.had_digits) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("tb_top: mismatch exp value=%0d end=%0d ovf=%0b dig=%0b",
                     want.value, want.end_offset, want.overflow, want.had_digits);
            $display("tb_top:          got value=%0d end=%0d ovf=%0b dig=%0b",
                     out_item.value, out_item.end_offset, out_item.overflow,
                     out_item.had_digits);
          end
        end
      end
    end
  end

  // cycles without any item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb_top: no progress for %0d cycles, %0d results outstanding",
             STUCK_LIMIT, parsed_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic f);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_item.ch    <= c;
    in_item.first <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(in_item);
    chars_sent++;
  endtask

  task automatic send_seq(input logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == 0);
  endtask

  task automatic send_text(input string s, input int tail = -1);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    if (tail >= 0) txt.push_back(tail[7:0]);
    send_seq(txt);
  endtask

  // let every result out and the internal queue drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [5:0] r);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_cur = r;
    radix_writes++;
  endtask

  // one string: mostly well-formed numbers, some noise and cut-off strings
  task automatic send_random_string();
    logic [7:0] txt[$];
    int         kind;
    int         ndig;
    int         maxd;
    int         dv;
    int         r;
    bit         hex;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(255)));
      send_seq(txt);
      return;
    end
    repeat ($urandom_range(0, 2)) txt.push_back(sitp_pkg::CH_SPACE);
    case ($urandom_range(3))
      1: txt.push_back(sitp_pkg::CH_PLUS);
      2: txt.push_back(sitp_pkg::CH_MINUS);
      3: txt.push_back(sitp_pkg::CH_SOFT_MINUS);
      default: ;
    endcase
    hex = 1'b0;
    if ((radix_cur == sitp_pkg::BASE_AUTO || radix_cur == sitp_pkg::BASE_HEX) &&
        $urandom_range(2) == 0) begin
      hex = 1'b1;
      txt.push_back(sitp_pkg::CH_ZERO);
      txt.push_back($urandom_range(1) ? sitp_pkg::CH_LO_X : sitp_pkg::CH_UP_X);
    end
    if (hex) maxd = 15;
    else if (radix_cur == sitp_pkg::BASE_AUTO) maxd = 9;
    else if (radix_cur > 36) maxd = 35;
    else maxd = (radix_cur == 0) ? 0 : radix_cur - 1;
    ndig = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
    repeat (ndig) begin
      if ($urandom_range(19) == 0) begin
        txt.push_back(8'($urandom_range(255)));
      end else begin
        dv = $urandom_range(maxd);
        if (dv < 10) txt.push_back(sitp_pkg::CH_ZERO + 8'(dv));
        else txt.push_back(($urandom_range(1) ? sitp_pkg::CH_LO_A : sitp_pkg::CH_UP_A) +
                           8'(dv - 10));
      end
    end
    r = $urandom_range(99);
    if (kind < 16) begin
      // cut off: the next start abandons it
    end else if (r < 50) begin
      txt.push_back(CH_NUL);
    end else if (r < 80) begin
      txt.push_back(8'($urandom_range(255)));
    end else begin
      txt.push_back(sitp_pkg::CH_SPACE);
    end
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 2)) txt.push_back(8'($urandom_range(255)));
    send_seq(txt);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  // reset radix of ten, stray bytes before a start and after a result
  task automatic test_reset_radix();
    send_byte("5", 1'b0);
    send_text(" +42", CH_NUL);
    send_text("-7", sitp_pkg::CH_SPACE);
    send_byte("9", 1'b0);
  endtask

  // automatic base detection, soft minus, hex prefix cases
  task automatic test_prefix_and_sign();
    set_radix(sitp_pkg::BASE_AUTO);
    send_text("0x1F", CH_NUL);
    send_text("0Xg");
    send_text(" 017", CH_NUL);
    send_byte(sitp_pkg::CH_SOFT_MINUS, 1'b1);
    send_byte("9", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_text("0", CH_NUL);
    set_radix(sitp_pkg::BASE_HEX);
    send_text("-0x80000000", CH_NUL);
    send_text("0x7FFFFFFF", sitp_pkg::CH_SPACE);
    send_text("0x80000000", sitp_pkg::CH_SPACE);
  endtask

  // signed limits, overflow, no digits, radix one and radix above 36
  task automatic test_limits();
    set_radix(sitp_pkg::BASE_DEC);
    send_text("2147483647", CH_NUL);
    send_text("-2147483648", CH_NUL);
    send_text("2147483648", CH_NUL);
    send_text("-99999999999999", CH_NUL);
    send_text("-", CH_NUL);
    set_radix(6'd1);
    send_text("001", CH_NUL);
    set_radix(6'd2);
    send_text("1011", CH_NUL);
    set_radix(6'd36);
    send_text("zZ", CH_NUL);
    set_radix(6'd63);
    send_text("zz", CH_NUL);
  endtask

  // a start mid-string abandons the string in progress
  task automatic test_restart();
    set_radix(sitp_pkg::BASE_DEC);
    send_text("123");
    send_text("45", CH_NUL);
  endtask

  // position keeps counting over a long run of leading spaces
  task automatic test_long_string();
    set_radix(sitp_pkg::BASE_DEC);
    send_byte(sitp_pkg::CH_SPACE, 1'b1);
    repeat (40) send_byte(sitp_pkg::CH_SPACE, 1'b0);
    send_byte("7", 1'b0);
    send_byte(CH_NUL, 1'b0);
  endtask

  task automatic test_random(input int phase);
    int start;
    int r;
    for (int k = 0; k < 4; k++) begin
      r = radix_plan[phase * 4 + k];
      set_radix((r == RADIX_RANDOM) ? 6'($urandom_range(63)) : 6'(r));
      start = chars_sent;
      while (chars_sent - start < BLOCK_CHARS) send_random_string();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle = 14;
    rx_idle = 65;
    test_reset_radix();
    test_prefix_and_sign();
    test_limits();
    test_restart();
    test_random(0);

    tx_idle = 65;
    rx_idle = 14;
    test_random(1);

    tx_idle = 0;
    rx_idle = 0;
    test_random(2);
    test_long_string();

    wait_idle();
    errors += parsed_q.size();
    $display("tb_top: %0d characters sent, %0d results checked, %0d radix writes",
             chars_sent, results_seen, radix_writes);
    $display("tb_top: %0d saturated results, %0d results without digits",
             saturated_cnt, no_digit_cnt);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
